// File: rtl/nearest_palette_color_snap_defines.svh
// ----------------------------------------------------------------------------
// Nearest palette color snap: assertion macros
// Concurrent assertion wrappers on clk_i, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SNAP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SNAP_DEFINES_SVH

`ifndef SYNTHESIS
// check outside reset
`define NPCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// check at every edge, reset included
`define NPCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define NPCS_ASSERT(lbl, prop, msg)
`define NPCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// Nearest palette color snap: package
// Sizes, item types, register codes and lane helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  localparam int unsigned PaletteDepth = 16;
  localparam int unsigned TreeLevels   = $clog2(PaletteDepth);
  localparam int unsigned NumLanes     = 1 << TreeLevels;
  localparam int unsigned LaneIdxW     = (TreeLevels > 0) ? TreeLevels : 1;
  localparam int unsigned NumStages    = TreeLevels + 4;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned SqW      = 2 * ChanW;
  localparam int unsigned WeightW  = 4;
  localparam int unsigned SizeW    = 5;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned DistW    = SqW + WeightW + 2;

  localparam logic [WeightW-1:0] RedWeightRst   = 4'd2;
  localparam logic [WeightW-1:0] GreenWeightRst = 4'd4;
  localparam logic [WeightW-1:0] BlueWeightRst  = 4'd3;
  localparam logic [SizeW-1:0]   SizeRst        = 5'd0;

  typedef enum logic {
    ActLoad  = 1'b0,
    ActPixel = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRedWeight   = 2'd0,
    CfgGreenWeight = 2'd1,
    CfgBlueWeight  = 2'd2,
    CfgPaletteSize = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    action_e           action;
    logic [IndexW-1:0] entry_index;
    logic [ChanW-1:0]  in_red;
    logic [ChanW-1:0]  in_green;
    logic [ChanW-1:0]  in_blue;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]  out_red;
    logic [ChanW-1:0]  out_green;
    logic [ChanW-1:0]  out_blue;
    logic [IndexW-1:0] chosen_index;
    logic              empty_palette;
  } out_item_t;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [SqW-1:0] r;
    logic [SqW-1:0] g;
    logic [SqW-1:0] b;
  } sq_t;

  typedef struct packed {
    logic                act;
    logic [DistW-1:0]    score;
    logic [LaneIdxW-1:0] idx;
    rgb_t                color;
  } node_t;

  function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // lower lane wins on a tie
  function automatic node_t pick(node_t lo, node_t hi);
    if (lo.act && (!hi.act || (lo.score <= hi.score))) begin
      return lo;
    end
    return hi;
  endfunction

endpackage

`default_nettype wire

// File: rtl/npcs_in_if.sv
// ----------------------------------------------------------------------------
// Nearest palette color snap: input channel
// Valid/ready channel for load and pixel items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface npcs_in_if;
  logic               valid;
  logic               ready;
  npcs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/npcs_out_if.sv
// ----------------------------------------------------------------------------
// Nearest palette color snap: result channel
// Valid/ready channel for snapped color items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface npcs_out_if;
  logic                valid;
  logic                ready;
  npcs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/nearest_palette_color_snap.sv
// ----------------------------------------------------------------------------
// Nearest palette color snap
// Weighted RGB distance to every active palette entry, lowest index on ties.
//
//   channel  | dir | handshake      | payload
//   pix_i    | in  | valid / ready  | action, entry_index, in_red/green/blue
//   res_o    | out | valid / ready  | out_red/green/blue, chosen_index, empty
//   cfg_*_i  | in  | cfg_we_i       | cfg_idx_i, cfg_data_i
//
// One item per cycle while res_o keeps up. A pixel result passes through
// registers in order: diff, square, weighted sum, one compare level per
// register, output register. A load item writes its entry in the accepting
// cycle and gives no result. Reset clears the valid bits and sets weights
// and size to reset values; palette entries hold nothing until loaded.
// A full stage holds while the next cannot move; empty stages keep filling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_snap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [npcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [npcs_pkg::CfgDataW-1:0] cfg_data_i,
  npcs_in_if.sink                       pix_i,
  npcs_out_if.source                    res_o
);
  import npcs_pkg::*;

`include "nearest_palette_color_snap_defines.svh"

  logic [WeightW-1:0] wr_q, wg_q, wb_q;
  logic [SizeW-1:0]   size_q;

  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] vld_q, vld_d;

  logic in_acc, in_pixel, in_load;
  rgb_t in_rgb;

  rgb_t pal_q [PaletteDepth];

  rgb_t lane_color [NumLanes];
  logic [NumLanes-1:0] lane_act;

  rgb_t                s1_pix_q;
  logic                s1_empty_q;
  logic [NumLanes-1:0] s1_act_q;
  rgb_t                s1_diff_q  [NumLanes];
  rgb_t                s1_color_q [NumLanes];

  rgb_t                s2_pix_q;
  logic                s2_empty_q;
  logic [NumLanes-1:0] s2_act_q;
  sq_t                 s2_sq_q    [NumLanes];
  rgb_t                s2_color_q [NumLanes];

  node_t node_q  [TreeLevels+1][NumLanes];
  rgb_t  tpix_q  [TreeLevels+1];
  logic  tempty_q[TreeLevels+1];

  out_item_t out_q;
  node_t     best;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= RedWeightRst;
      wg_q   <= GreenWeightRst;
      wb_q   <= BlueWeightRst;
      size_q <= SizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgRedWeight:   wr_q   <= cfg_data_i[WeightW-1:0];
        CfgGreenWeight: wg_q   <= cfg_data_i[WeightW-1:0];
        CfgBlueWeight:  wb_q   <= cfg_data_i[WeightW-1:0];
        CfgPaletteSize: size_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  always_comb begin
    rdy[NumStages] = res_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign pix_i.ready = rdy[0];
  assign in_acc      = pix_i.valid && rdy[0];
  assign in_pixel    = pix_i.data.action == ActPixel;
  assign in_load     = in_acc && (pix_i.data.action == ActLoad);
  assign in_rgb      = '{r: pix_i.data.in_red, g: pix_i.data.in_green, b: pix_i.data.in_blue};

  always_comb begin
    vld_d[0] = rdy[0] ? (in_acc && in_pixel) : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // palette
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < PaletteDepth; e++) begin
      if (in_load && (32'(pix_i.data.entry_index) == 32'(e))) begin
        pal_q[e] <= in_rgb;
      end
    end
  end

  for (genvar j = 0; j < NumLanes; j++) begin : g_lane
    if (j < PaletteDepth) begin : g_used
      assign lane_color[j] = pal_q[j];
      assign lane_act[j]   = 32'(j) < 32'(size_q);
    end else begin : g_pad
      assign lane_color[j] = '0;
      assign lane_act[j]   = 1'b0;
    end
  end

  // stage 1: channel differences
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_pix_q   <= in_rgb;
      s1_empty_q <= size_q == '0;
      s1_act_q   <= lane_act;
      for (int j = 0; j < NumLanes; j++) begin
        s1_diff_q[j]  <= '{r: abs_diff(lane_color[j].r, in_rgb.r),
                           g: abs_diff(lane_color[j].g, in_rgb.g),
                           b: abs_diff(lane_color[j].b, in_rgb.b)};
        s1_color_q[j] <= lane_color[j];
      end
    end
  end

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_pix_q   <= s1_pix_q;
      s2_empty_q <= s1_empty_q;
      s2_act_q   <= s1_act_q;
      for (int j = 0; j < NumLanes; j++) begin
        s2_sq_q[j]    <= '{r: SqW'(s1_diff_q[j].r) * SqW'(s1_diff_q[j].r),
                           g: SqW'(s1_diff_q[j].g) * SqW'(s1_diff_q[j].g),
                           b: SqW'(s1_diff_q[j].b) * SqW'(s1_diff_q[j].b)};
        s2_color_q[j] <= s1_color_q[j];
      end
    end
  end

  // stage 3: weighted distance
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      tpix_q[0]   <= s2_pix_q;
      tempty_q[0] <= s2_empty_q;
      for (int j = 0; j < NumLanes; j++) begin
        node_q[0][j].act   <= s2_act_q[j];
        node_q[0][j].score <= DistW'(wr_q) * DistW'(s2_sq_q[j].r)
                            + DistW'(wg_q) * DistW'(s2_sq_q[j].g)
                            + DistW'(wb_q) * DistW'(s2_sq_q[j].b);
        node_q[0][j].idx   <= LaneIdxW'(j);
        node_q[0][j].color <= s2_color_q[j];
      end
    end
  end

  // compare tree, one level per stage
  for (genvar l = 1; l <= TreeLevels; l++) begin : g_lvl
    always_ff @(posedge clk_i) begin
      if (rdy[2+l]) begin
        tpix_q[l]   <= tpix_q[l-1];
        tempty_q[l] <= tempty_q[l-1];
        for (int j = 0; j < (NumLanes >> l); j++) begin
          node_q[l][j] <= pick(node_q[l-1][2*j], node_q[l-1][2*j+1]);
        end
      end
    end
  end

  // output register
  assign best = node_q[TreeLevels][0];

  always_ff @(posedge clk_i) begin
    if (rdy[NumStages-1]) begin
      if (tempty_q[TreeLevels]) begin
        out_q.out_red      <= tpix_q[TreeLevels].r;
        out_q.out_green    <= tpix_q[TreeLevels].g;
        out_q.out_blue     <= tpix_q[TreeLevels].b;
        out_q.chosen_index <= '0;
      end else begin
        out_q.out_red      <= best.color.r;
        out_q.out_green    <= best.color.g;
        out_q.out_blue     <= best.color.b;
        out_q.chosen_index <= IndexW'(best.idx);
      end
      out_q.empty_palette <= tempty_q[TreeLevels];
    end
  end

  assign res_o.valid = vld_q[NumStages-1];
  assign res_o.data  = out_q;

  `NPCS_ASSERT(a_load_no_item, (in_load |=> !vld_q[0]),
               "load item entered the pipeline")
  `NPCS_ASSERT(a_pixel_enters, (in_acc && in_pixel |=> vld_q[0]),
               "pixel item was dropped")
  `NPCS_ASSERT(a_idle_ready, (!res_o.valid |-> pix_i.ready),
               "input stalled with output free")
  `NPCS_ASSERT(a_empty_index,
               (res_o.valid && res_o.data.empty_palette |-> res_o.data.chosen_index == '0),
               "empty palette with nonzero index")
  `NPCS_ASSERT_ALWAYS(a_reset_clear, (!rst_ni |=> !res_o.valid),
                      "result valid after reset")

endmodule

`default_nettype wire
